FILE: rtl/aire_pkg.sv
package aire_pkg;

	// Instruction categories, same code on every emitted word
	typedef enum logic [1:0] {
		CAT_OTHER  = 2'd0,
		CAT_BRANCH = 2'd1,
		CAT_BL     = 2'd2,
		CAT_PCLOAD = 2'd3
	} cat_t;

	// Word kinds
	localparam logic KIND_FINAL = 1'b0;
	localparam logic KIND_ADDR  = 1'b1;

	// Classification masks and patterns
	localparam logic [31:0] BR_MASK  = 32'h0F00_0000;
	localparam logic [31:0] BR_OP    = 32'h0A00_0000;
	localparam logic [31:0] BL_OP    = 32'h0B00_0000;
	localparam logic [31:0] PCL_MASK = 32'h0F2F_0000;
	localparam logic [31:0] PCL_OP   = 32'h050F_0000;

	// Fixed load encodings (condition field supplied separately where needed)
	localparam logic [27:0] LDR_PC_PC_P0 = 28'h59F_F000; // ldr pc, [pc, #0]
	localparam logic [27:0] LDR_LR_PC_P4 = 28'h59F_E004; // ldr lr, [pc, #4]
	localparam logic [27:0] LDR_PC_PC_P4 = 28'h59F_F004; // ldr pc, [pc, #4]
	localparam logic [31:0] LDR_AL_M16   = 32'hE51F_F010; // ldr pc, [pc, #-16]
	localparam logic [31:0] LDR_AL_M20   = 32'hE51F_F014; // ldr pc, [pc, #-20]
	localparam logic [31:0] IMM12_MASK   = 32'h0000_0FFF;

	// Word index of the trampoline
	localparam int IdxW = 3;
	typedef logic [IdxW-1:0] idx_t;

	// Queue between front and back
	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// One classified instruction
	typedef struct packed {
		cat_t        cat;
		logic [31:0] insn;
		logic [31:0] ret_addr; // address + 4
		logic [31:0] tail;     // branch target or literal source address
	} entry_t;

	// Index of the closing word for each category
	function automatic idx_t last_index(cat_t cat);
		idx_t r;
		r = '0;
		unique case (cat)
			CAT_OTHER:  r = IdxW'(1);
			CAT_BRANCH: r = IdxW'(2);
			CAT_BL:     r = IdxW'(4);
			CAT_PCLOAD: r = IdxW'(2);
			default:    r = IdxW'(1);
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/arm_insn_relocation_emitter.sv
// Flow: an accepted instruction is written into the queue; its first trampoline word
// is loaded into the output register when that register is free or being taken.
// Output: 2, 3 or 5 words per instruction, one word per cycle unless tramp_ready
// stalls the back end; the two-entry queue holds the input off only while both
// entries wait.
// Reset: arst_n asynchronously empties the queue and clears the output valid.
module arm_insn_relocation_emitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_ready,
	input  logic [31:0] instr_word,
	input  logic [31:0] instr_address,
	output logic        tramp_valid,
	input  logic        tramp_ready,
	output logic [31:0] out_word,
	output logic        word_kind,
	output logic [2:0]  word_index,
	output logic [1:0]  category,
	output logic        last_word
);
	import aire_pkg::*;

	entry_t front_entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   head_valid;

	assign instr_ready = !q_full;

	// Classification and address arithmetic
	aire_front u_front (
		.instr_valid  (instr_valid),
		.instr_word   (instr_word),
		.instr_address(instr_address),
		.q_full       (q_full),
		.push         (push),
		.entry        (front_entry)
	);

	// Decoupling queue
	aire_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (front_entry),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head)
	);

	// Word sequencer
	aire_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tramp_valid(tramp_valid),
		.tramp_ready(tramp_ready),
		.out_word   (out_word),
		.word_kind  (word_kind),
		.word_index (word_index),
		.category   (category),
		.last_word  (last_word)
	);

endmodule

FILE: rtl/aire_front.sv
module aire_front (
	input  logic             instr_valid,
	input  logic [31:0]      instr_word,
	input  logic [31:0]      instr_address,
	input  logic             q_full,
	output logic             push,
	output aire_pkg::entry_t entry
);
	import aire_pkg::*;

	logic [31:0] pc8;
	logic [31:0] br_off;
	logic [31:0] lit_off;
	logic [31:0] target;
	logic [31:0] lit_src;
	cat_t        cat;

	// Classify
	always_comb begin
		priority if ((instr_word & BR_MASK) == BR_OP) begin
			cat = CAT_BRANCH;
		end else if ((instr_word & BR_MASK) == BL_OP) begin
			cat = CAT_BL;
		end else if ((instr_word & PCL_MASK) == PCL_OP) begin
			cat = CAT_PCLOAD;
		end else begin
			cat = CAT_OTHER;
		end
	end

	// Address arithmetic: branch target and literal source
	assign pc8     = instr_address + 32'd8;
	assign br_off  = {{6{instr_word[23]}}, instr_word[23:0], 2'b00};
	assign lit_off = {20'd0, instr_word[11:0]};
	assign target  = pc8 + br_off;
	assign lit_src = instr_word[23] ? (pc8 + lit_off) : (pc8 - lit_off);

	always_comb begin
		entry.cat      = cat;
		entry.insn     = instr_word;
		entry.ret_addr = instr_address + 32'd4;
		entry.tail     = (cat == CAT_PCLOAD) ? lit_src : target;
	end

	assign push = instr_valid && !q_full;

endmodule

FILE: rtl/aire_queue.sv
module aire_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  aire_pkg::entry_t wr_entry,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output aire_pkg::entry_t head
);
	import aire_pkg::*;

	entry_t            slot_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  cnt_q;

	assign full       = (cnt_q == QCntW'(QDepth));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");

endmodule

FILE: rtl/aire_back.sv
module aire_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  aire_pkg::entry_t head,
	output logic             pop,
	output logic             tramp_valid,
	input  logic             tramp_ready,
	output logic [31:0]      out_word,
	output logic             word_kind,
	output logic [2:0]       word_index,
	output logic [1:0]       category,
	output logic             last_word
);
	import aire_pkg::*;

	idx_t        idx_q;
	logic        out_valid_q;
	logic [31:0] word_q;
	logic        kind_q;
	idx_t        index_q;
	cat_t        cat_q;
	logic        last_q;

	logic        load;
	logic        is_last;
	logic [31:0] word_nxt;
	logic        kind_nxt;
	logic [3:0]  cond;

	assign cond    = head.insn[31:28];
	assign load    = !out_valid_q || tramp_ready;
	assign is_last = (idx_q == last_index(head.cat));
	assign pop     = load && head_valid && is_last;

	// Select the trampoline word for the current index
	always_comb begin
		word_nxt = LDR_AL_M16;
		kind_nxt = KIND_FINAL;
		unique case (head.cat)
			CAT_OTHER: begin
				word_nxt = (idx_q == '0) ? head.insn : LDR_AL_M16;
			end
			CAT_BRANCH: begin
				if (idx_q == '0) begin
					word_nxt = {cond, LDR_PC_PC_P0};
				end else if (idx_q == IdxW'(1)) begin
					word_nxt = LDR_AL_M16;
				end else begin
					word_nxt = head.tail;
				end
			end
			CAT_BL: begin
				unique case (idx_q)
					IdxW'(0): word_nxt = {cond, LDR_LR_PC_P4};
					IdxW'(1): word_nxt = {cond, LDR_PC_PC_P4};
					IdxW'(2): word_nxt = LDR_AL_M20;
					IdxW'(3): word_nxt = head.ret_addr;
					default:  word_nxt = head.tail;
				endcase
			end
			CAT_PCLOAD: begin
				if (idx_q == '0) begin
					word_nxt = head.insn & ~IMM12_MASK;
				end else if (idx_q == IdxW'(1)) begin
					word_nxt = LDR_AL_M16;
				end else begin
					word_nxt = head.tail;
					kind_nxt = KIND_ADDR;
				end
			end
			default: begin
				word_nxt = LDR_AL_M16;
			end
		endcase
	end

	// Word counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (load && head_valid) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			word_q  <= word_nxt;
			kind_q  <= kind_nxt;
			index_q <= idx_q;
			cat_q   <= head.cat;
			last_q  <= is_last;
		end
	end

	assign tramp_valid = out_valid_q;
	assign out_word    = word_q;
	assign word_kind   = kind_q;
	assign word_index  = index_q;
	assign category    = cat_q;
	assign last_word   = last_q;

	a_mid_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> head_valid)
		else $error("trampoline in progress without a queued entry");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> index_q == last_index(cat_q))
		else $error("closing word at wrong index");
	a_addr_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q |-> cat_q == CAT_PCLOAD && last_q)
		else $error("address word outside a literal load");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import aire_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        instr_valid = 1'b0;
	logic        instr_ready;
	logic [31:0] instr_word = '0;
	logic [31:0] instr_address = '0;
	logic        tramp_valid;
	logic        tramp_ready = 1'b0;
	logic [31:0] out_word;
	logic        word_kind;
	logic [2:0]  word_index;
	logic [1:0]  category;
	logic        last_word;

	// no random idling on either side while set
	logic steady = 1'b0;

	arm_insn_relocation_emitter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.instr_valid   (instr_valid),
		.instr_ready   (instr_ready),
		.instr_word    (instr_word),
		.instr_address (instr_address),
		.tramp_valid   (tramp_valid),
		.tramp_ready   (tramp_ready),
		.out_word      (out_word),
		.word_kind     (word_kind),
		.word_index    (word_index),
		.category      (category),
		.last_word     (last_word)
	);

	// One expected trampoline word
	typedef struct {
		logic [31:0] word;
		logic        kind;
		logic [2:0]  idx;
		cat_t        cat;
		logic        last;
	} tramp_word_t;

	// Single-register word load: LDR<cond> rd, [rn, #off]
	function automatic logic [31:0] ldr_word(logic [3:0] cond, logic [3:0] rd,
			logic [3:0] rn, int off);
		logic [11:0] mag;
		mag = (off < 0) ? 12'(-off) : 12'(off);
		return {cond, 4'b0101, (off >= 0), 3'b001, rn, rd, mag};
	endfunction

	// Scoreboard: builds the trampoline for each instruction transaction
	class tramp_scoreboard;
		tramp_word_t pending[$];
		int          n_instr;
		int          n_words;
		int          n_errors;
		int          cat_seen[4];
		int          base_count;

		function void push_word(logic [31:0] w, logic kind, cat_t cat, logic last);
			tramp_word_t e;
			e.word = w;
			e.kind = kind;
			e.idx  = 3'(pending.size() - base_count);
			e.cat  = cat;
			e.last = last;
			pending.push_back(e);
		endfunction

		function void note_instruction(logic [31:0] insn, logic [31:0] addr);
			logic [3:0]  cond;
			logic [31:0] target;
			logic [31:0] lit_off;
			logic [31:0] src;
			cond       = insn[31:28];
			target     = addr + 32'd8 + ({{8{insn[23]}}, insn[23:0]} << 2);
			lit_off    = {20'd0, insn[11:0]};
			base_count = pending.size();
			n_instr++;
			if (insn[27:24] == 4'b1010) begin
				cat_seen[CAT_BRANCH]++;
				push_word(ldr_word(cond, 4'd15, 4'd15, 0), KIND_FINAL, CAT_BRANCH, 1'b0);
				push_word(ldr_word(4'hE, 4'd15, 4'd15, -16), KIND_FINAL, CAT_BRANCH, 1'b0);
				push_word(target, KIND_FINAL, CAT_BRANCH, 1'b1);
			end else if (insn[27:24] == 4'b1011) begin
				cat_seen[CAT_BL]++;
				push_word(ldr_word(cond, 4'd14, 4'd15, 4), KIND_FINAL, CAT_BL, 1'b0);
				push_word(ldr_word(cond, 4'd15, 4'd15, 4), KIND_FINAL, CAT_BL, 1'b0);
				push_word(ldr_word(4'hE, 4'd15, 4'd15, -20), KIND_FINAL, CAT_BL, 1'b0);
				push_word(addr + 32'd4, KIND_FINAL, CAT_BL, 1'b0);
				push_word(target, KIND_FINAL, CAT_BL, 1'b1);
			end else if (insn[27:24] == 4'b0101 && !insn[21] && insn[19:16] == 4'hF) begin
				// PC-relative load or store; U bit picks the offset sign
				cat_seen[CAT_PCLOAD]++;
				src = insn[23] ? addr + 32'd8 + lit_off : addr + 32'd8 - lit_off;
				push_word({insn[31:12], 12'd0}, KIND_FINAL, CAT_PCLOAD, 1'b0);
				push_word(ldr_word(4'hE, 4'd15, 4'd15, -16), KIND_FINAL, CAT_PCLOAD, 1'b0);
				push_word(src, KIND_ADDR, CAT_PCLOAD, 1'b1);
			end else begin
				cat_seen[CAT_OTHER]++;
				push_word(insn, KIND_FINAL, CAT_OTHER, 1'b0);
				push_word(ldr_word(4'hE, 4'd15, 4'd15, -16), KIND_FINAL, CAT_OTHER, 1'b1);
			end
		endfunction

		function void check_word(logic [31:0] w, logic kind, logic [2:0] idx,
				logic [1:0] cat, logic last);
			tramp_word_t e;
			n_words++;
			if (pending.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: unexpected word %08h idx %0d cat %0d", w, idx, cat);
				return;
			end
			e = pending.pop_front();
			if (w !== e.word || kind !== e.kind || idx !== e.idx ||
					cat !== 2'(e.cat) || last !== e.last) begin
				n_errors++;
				if (n_errors <= 10) begin
					$display("ERROR: word mismatch: exp %08h kind %0d idx %0d cat %0d last %0d",
						e.word, e.kind, e.idx, e.cat, e.last);
					$display("ERROR:                got %08h kind %0d idx %0d cat %0d last %0d",
						w, kind, idx, cat, last);
				end
			end
		endfunction
	endclass

	tramp_scoreboard board;

	// Clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Offer one instruction and hold it until the transaction completes
	task automatic send_instr(input logic [31:0] insn, input logic [31:0] addr);
		while (!steady && $urandom_range(99) < 16) begin
			instr_valid <= 1'b0;
			@(posedge clk);
		end
		instr_valid   <= 1'b1;
		instr_word    <= insn;
		instr_address <= addr;
		do @(posedge clk); while (!instr_ready);
		board.note_instruction(insn, addr);
	endtask

	function automatic logic [31:0] pick_address();
		case ($urandom_range(15))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFC;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Result side: check each accepted word, stall at random
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (tramp_valid && tramp_ready)
				board.check_word(out_word, word_kind, word_index, category, last_word);
			tramp_ready <= steady || ($urandom_range(99) >= 16);
		end
	end

	// Stimulus
	initial begin
		int          flip_bits[9] = '{27, 26, 25, 24, 21, 19, 18, 17, 16};
		logic [31:0] insn;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each category, load/store variants, near misses
		send_instr(32'h0000_0000, 32'h0000_0000);
		send_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_instr(32'hEA7F_FFFF, 32'h0000_1000);
		send_instr(32'h0A80_0000, 32'h0000_0000);
		send_instr(32'h1AFF_FFFE, 32'hFFFF_FFF8);
		send_instr(32'hEB00_0000, 32'h1234_5678);
		send_instr(32'hFB80_0000, 32'hFFFF_FFFC);
		send_instr(32'h0BFF_FFFF, 32'h8000_0000);
		send_instr(32'hE59F_0FFF, 32'hFFFF_FFF8);
		send_instr(32'hE51F_0FFF, 32'h0000_0000);
		send_instr(32'hE58F_1004, 32'h0000_4000);
		send_instr(32'hE5DF_2001, 32'h0000_4001);
		send_instr(32'hE5CF_3003, 32'h0000_4003);
		send_instr(32'hE5BF_0004, 32'h0000_4004);
		send_instr(32'hE79F_0001, 32'h0000_4008);
		send_instr(32'hE59E_0004, 32'h0000_400C);
		send_instr(32'hE49F_0004, 32'h0000_4010);
		send_instr(32'hED9F_0000, 32'h0000_4014);
		send_instr(32'hE19F_0000, 32'h0000_4018);
		send_instr(32'h059F_F000, 32'hFFFF_FFFF);
		send_instr(32'hE59F_0000, 32'h7FFF_FFFC);

		// random: mostly well-formed branches and literal loads, some near misses
		for (int i = 0; i < 410; i++) begin
			steady = (i >= 150 && i < 260);
			insn   = $urandom;
			case ($urandom_range(9))
				0, 1:    insn[27:24] = 4'b1010;
				2, 3:    insn[27:24] = 4'b1011;
				4, 5, 6: insn = (insn & ~32'h0F2F_0000) | 32'h050F_0000;
				7:       insn = ((insn & ~32'h0F2F_0000) | 32'h050F_0000) ^
						(32'd1 << flip_bits[$urandom_range(8)]);
				default: ;
			endcase
			send_instr(insn, pick_address());
		end
		steady = 1'b0;
		instr_valid <= 1'b0;

		// drain, then wait for stray words
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run: %0d instructions (other %0d, branch %0d, link %0d, pc load %0d)",
			board.n_instr, board.cat_seen[CAT_OTHER], board.cat_seen[CAT_BRANCH],
			board.cat_seen[CAT_BL], board.cat_seen[CAT_PCLOAD]);
		$display("Run: %0d trampoline words checked, %0d mismatches",
			board.n_words, board.n_errors);
		if (board.n_errors == 0 && board.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#400us;
		$display("ERROR: timeout, %0d words still expected", board.pending.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
